FILE: sv/gbfp_pkg.sv
//==============================================================================
// gbfp_pkg
// Shared types and constants for the binary GNSS frame parser
//==============================================================================
`default_nettype none

package gbfp_pkg;

    // default sizes and limits
    localparam int FRAME_DEPTH    = 256;
    localparam int PAYLOAD_DEPTH  = 256;
    localparam int MAX_RESULTS    = 32;
    localparam int FRAME_OVERHEAD = 6;
    localparam int HEADER_BYTES   = 4;

    // register reset values
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h62;
    localparam logic [7:0] MAX_LEN_RST     = 8'd172;

    // register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

    typedef enum logic [1:0] {
        KIND_VALID = 2'd0,
        KIND_CSUM  = 2'd1,
        KIND_LEN   = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic {
        PH_HUNT  = 1'b0,
        PH_FRAME = 1'b1
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TOP,
        ST_H0,
        ST_H1,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_CK_IS,
        ST_CK_AC,
        ST_CS_IS,
        ST_CS0,
        ST_CS1,
        ST_RD_DATA,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } item_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] max_len;
    } cfg_t;

endpackage

`default_nettype wire

FILE: sv/gbfp_front.sv
//==============================================================================
// gbfp_front
// Input side: two-entry item queue feeding the parse engine
//==============================================================================
`default_nettype none

module gbfp_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire gbfp_pkg::item_t s_item,
    output logic                 q_valid,
    output gbfp_pkg::item_t      q_item,
    input  wire logic            q_pop
);

    gbfp_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    // pointer and count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // item storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

`default_nettype wire

FILE: sv/gbfp_back.sv
//==============================================================================
// gbfp_back
// Parse engine: frame buffer, sync hunt, checksum pass, kept payload, results
//==============================================================================
`default_nettype none

module gbfp_back #(
    parameter int FRAME_DEPTH   = gbfp_pkg::FRAME_DEPTH,
    parameter int PAYLOAD_DEPTH = gbfp_pkg::PAYLOAD_DEPTH,
    parameter int MAX_RESULTS   = gbfp_pkg::MAX_RESULTS
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire gbfp_pkg::cfg_t  cfg,
    input  wire logic            q_valid,
    input  wire gbfp_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output gbfp_pkg::kind_t      m_kind,
    output logic [7:0]           m_cls,
    output logic [7:0]           m_id,
    output logic [15:0]          m_len,
    output logic [7:0]           m_data
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int PW = $clog2(PAYLOAD_DEPTH);
    localparam int NW = $clog2(MAX_RESULTS + 1);
    localparam logic [AW:0]   DEPTH_C     = (AW+1)'(FRAME_DEPTH);
    localparam logic [15:0]   FRAME_LIMIT = 16'(FRAME_DEPTH - gbfp_pkg::FRAME_OVERHEAD);
    localparam logic [15:0]   PDEPTH_C    = 16'(PAYLOAD_DEPTH);
    localparam logic [NW-1:0] NMAX_C      = NW'(MAX_RESULTS);

    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] r;
        r = (s >= DEPTH_C) ? (s - DEPTH_C) : s;
        return r[AW-1:0];
    endfunction

    gbfp_pkg::state_t state_reg, state_next;
    gbfp_pkg::phase_t phase_reg, phase_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW:0]   fill_reg, fill_next;
    logic [NW-1:0] n_reg, n_next;
    logic [7:0]    cls_reg, cls_next;
    logic [7:0]    id_reg, id_next;
    logic [7:0]    lo_reg, lo_next;
    logic [15:0]   len_reg, len_next;
    logic [8:0]    i_reg, i_next;
    logic [7:0]    sum_a_reg, sum_a_next;
    logic [7:0]    sum_b_reg, sum_b_next;
    logic [7:0]    ck_a_reg, ck_a_next;
    logic          bank_reg, bank_next;
    logic [7:0]    kept_cls_reg, kept_cls_next;
    logic [7:0]    kept_id_reg, kept_id_next;
    logic [15:0]   kept_len_reg, kept_len_next;
    logic [7:0]    ridx_reg, ridx_next;
    gbfp_pkg::kind_t ekind_reg, ekind_next;
    logic [7:0]    edata_reg, edata_next;
    logic          ret_idle_reg, ret_idle_next;
    logic          m_valid_reg, m_valid_next;
    gbfp_pkg::kind_t m_kind_reg, m_kind_next;
    logic [7:0]    m_cls_reg, m_cls_next;
    logic [7:0]    m_id_reg, m_id_next;
    logic [15:0]   m_len_reg, m_len_next;
    logic [7:0]    m_data_reg, m_data_next;

    // frame buffer memory
    logic [7:0]    fb_mem [FRAME_DEPTH];
    logic          fb_we;
    logic [AW-1:0] fb_waddr, fb_raddr;
    logic [AW:0]   fb_off;
    logic [7:0]    fb_rdata_reg;

    // kept payload memory, two banks
    logic [7:0]    kp_mem [2*PAYLOAD_DEPTH];
    logic          kp_we;
    logic [PW:0]   kp_waddr, kp_raddr;
    logic [7:0]    kp_rdata_reg;

    logic [15:0]   limit, len_w, pay_pos, ridx_ext;
    logic [7:0]    sum_a_new, sum_b_new;
    logic [8:0]    i_inc;
    logic          out_free, is_read;

    assign limit     = ({8'd0, cfg.max_len} > FRAME_LIMIT) ? FRAME_LIMIT
                                                           : {8'd0, cfg.max_len};
    assign len_w     = {fb_rdata_reg, lo_reg};
    assign sum_a_new = sum_a_reg + fb_rdata_reg;
    assign sum_b_new = sum_b_reg + sum_a_new;
    assign i_inc     = i_reg + 9'd1;
    assign pay_pos   = 16'(i_reg) - 16'(gbfp_pkg::HEADER_BYTES);
    assign ridx_ext  = {8'd0, q_item.read_index};
    assign out_free  = !m_valid_reg || m_ready;
    assign is_read   = q_item.req_type;
    assign q_pop     = (state_reg == gbfp_pkg::ST_IDLE) && q_valid;

    // buffer addressing
    always_comb begin
        case (state_reg)
            gbfp_pkg::ST_H0,
            gbfp_pkg::ST_F0:    fb_off = (AW+1)'(1);
            gbfp_pkg::ST_F1:    fb_off = (AW+1)'(2);
            gbfp_pkg::ST_F2:    fb_off = (AW+1)'(3);
            gbfp_pkg::ST_CK_IS: fb_off = (AW+1)'(i_reg);
            gbfp_pkg::ST_CS_IS: fb_off = (AW+1)'(len_reg + 16'd4);
            gbfp_pkg::ST_CS0:   fb_off = (AW+1)'(len_reg + 16'd5);
            default:            fb_off = '0;
        endcase
    end

    assign fb_raddr = wrap({1'b0, ptr_reg} + fb_off);
    assign fb_waddr = wrap({1'b0, ptr_reg} + fill_reg);
    assign fb_we    = q_pop && !is_read && (fill_reg < DEPTH_C);

    always_ff @(posedge aclk) begin
        if (fb_we) begin
            fb_mem[fb_waddr] <= q_item.rx_byte;
        end
        fb_rdata_reg <= fb_mem[fb_raddr];
    end

    // payload copy during the checksum pass into the idle bank
    assign kp_we    = (state_reg == gbfp_pkg::ST_CK_AC)
                      && (i_reg >= 9'(gbfp_pkg::HEADER_BYTES)) && (pay_pos < PDEPTH_C);
    assign kp_waddr = {~bank_reg, pay_pos[PW-1:0]};
    assign kp_raddr = {bank_reg, ridx_ext[PW-1:0]};

    always_ff @(posedge aclk) begin
        if (kp_we) begin
            kp_mem[kp_waddr] <= fb_rdata_reg;
        end
        kp_rdata_reg <= kp_mem[kp_raddr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gbfp_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = is_read ? gbfp_pkg::ST_RD_DATA : gbfp_pkg::ST_TOP;
                end
            end
            gbfp_pkg::ST_TOP: begin
                if (n_reg == NMAX_C) begin
                    state_next = gbfp_pkg::ST_IDLE;
                end else if (phase_reg == gbfp_pkg::PH_HUNT) begin
                    state_next = (fill_reg < (AW+1)'(2)) ? gbfp_pkg::ST_IDLE
                                                         : gbfp_pkg::ST_H0;
                end else begin
                    state_next = (fill_reg < (AW+1)'(4)) ? gbfp_pkg::ST_IDLE
                                                         : gbfp_pkg::ST_F0;
                end
            end
            gbfp_pkg::ST_H0: begin
                state_next = (fb_rdata_reg == cfg.sync_first) ? gbfp_pkg::ST_H1
                                                              : gbfp_pkg::ST_TOP;
            end
            gbfp_pkg::ST_H1: state_next = gbfp_pkg::ST_TOP;
            gbfp_pkg::ST_F0: state_next = gbfp_pkg::ST_F1;
            gbfp_pkg::ST_F1: state_next = gbfp_pkg::ST_F2;
            gbfp_pkg::ST_F2: state_next = gbfp_pkg::ST_F3;
            gbfp_pkg::ST_F3: begin
                if (len_w > limit) begin
                    state_next = gbfp_pkg::ST_EMIT;
                end else if (17'(fill_reg) < (17'(len_w) + 17'd6)) begin
                    state_next = gbfp_pkg::ST_IDLE;
                end else begin
                    state_next = gbfp_pkg::ST_CK_IS;
                end
            end
            gbfp_pkg::ST_CK_IS: state_next = gbfp_pkg::ST_CK_AC;
            gbfp_pkg::ST_CK_AC: begin
                state_next = (i_inc == (len_reg[8:0] + 9'd4)) ? gbfp_pkg::ST_CS_IS
                                                              : gbfp_pkg::ST_CK_IS;
            end
            gbfp_pkg::ST_CS_IS:   state_next = gbfp_pkg::ST_CS0;
            gbfp_pkg::ST_CS0:     state_next = gbfp_pkg::ST_CS1;
            gbfp_pkg::ST_CS1:     state_next = gbfp_pkg::ST_EMIT;
            gbfp_pkg::ST_RD_DATA: state_next = gbfp_pkg::ST_EMIT;
            gbfp_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = ret_idle_reg ? gbfp_pkg::ST_IDLE : gbfp_pkg::ST_TOP;
                end
            end
            default: state_next = gbfp_pkg::ST_IDLE;
        endcase
    end

    // datapath and result register updates
    always_comb begin
        phase_next    = phase_reg;
        ptr_next      = ptr_reg;
        fill_next     = fill_reg;
        n_next        = n_reg;
        cls_next      = cls_reg;
        id_next       = id_reg;
        lo_next       = lo_reg;
        len_next      = len_reg;
        i_next        = i_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        ck_a_next     = ck_a_reg;
        bank_next     = bank_reg;
        kept_cls_next = kept_cls_reg;
        kept_id_next  = kept_id_reg;
        kept_len_next = kept_len_reg;
        ridx_next     = ridx_reg;
        ekind_next    = ekind_reg;
        edata_next    = edata_reg;
        ret_idle_next = ret_idle_reg;
        m_valid_next  = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_kind_next   = m_kind_reg;
        m_cls_next    = m_cls_reg;
        m_id_next     = m_id_reg;
        m_len_next    = m_len_reg;
        m_data_next   = m_data_reg;
        unique case (state_reg)
            gbfp_pkg::ST_IDLE: begin
                if (q_valid) begin
                    n_next = '0;
                    if (is_read) begin
                        ridx_next     = q_item.read_index;
                        cls_next      = kept_cls_reg;
                        id_next       = kept_id_reg;
                        len_next      = kept_len_reg;
                        ekind_next    = gbfp_pkg::KIND_READ;
                        ret_idle_next = 1'b1;
                    end else if (fb_we) begin
                        fill_next = fill_reg + (AW+1)'(1);
                    end
                end
            end
            gbfp_pkg::ST_H0: begin
                if (fb_rdata_reg != cfg.sync_first) begin
                    ptr_next  = wrap({1'b0, ptr_reg} + (AW+1)'(1));
                    fill_next = fill_reg - (AW+1)'(1);
                end
            end
            gbfp_pkg::ST_H1: begin
                if (fb_rdata_reg == cfg.sync_second) begin
                    ptr_next   = wrap({1'b0, ptr_reg} + (AW+1)'(2));
                    fill_next  = fill_reg - (AW+1)'(2);
                    phase_next = gbfp_pkg::PH_FRAME;
                end else begin
                    ptr_next  = wrap({1'b0, ptr_reg} + (AW+1)'(1));
                    fill_next = fill_reg - (AW+1)'(1);
                end
            end
            gbfp_pkg::ST_F0: cls_next = fb_rdata_reg;
            gbfp_pkg::ST_F1: id_next  = fb_rdata_reg;
            gbfp_pkg::ST_F2: lo_next  = fb_rdata_reg;
            gbfp_pkg::ST_F3: begin
                len_next      = len_w;
                sum_a_next    = 8'd0;
                sum_b_next    = 8'd0;
                i_next        = 9'd0;
                ekind_next    = gbfp_pkg::KIND_LEN;
                edata_next    = 8'd0;
                ret_idle_next = 1'b0;
                if (len_w > limit) begin
                    phase_next = gbfp_pkg::PH_HUNT;
                end
            end
            gbfp_pkg::ST_CK_AC: begin
                sum_a_next = sum_a_new;
                sum_b_next = sum_b_new;
                i_next     = i_inc;
            end
            gbfp_pkg::ST_CS0: ck_a_next = fb_rdata_reg;
            gbfp_pkg::ST_CS1: begin
                phase_next = gbfp_pkg::PH_HUNT;
                if (ck_a_reg == sum_a_reg && fb_rdata_reg == sum_b_reg) begin
                    bank_next     = ~bank_reg;
                    kept_cls_next = cls_reg;
                    kept_id_next  = id_reg;
                    kept_len_next = len_reg;
                    ptr_next      = wrap({1'b0, ptr_reg} + (AW+1)'(len_reg + 16'd6));
                    fill_next     = fill_reg - (AW+1)'(len_reg + 16'd6);
                    ekind_next    = gbfp_pkg::KIND_VALID;
                end else begin
                    ekind_next = gbfp_pkg::KIND_CSUM;
                end
            end
            gbfp_pkg::ST_RD_DATA: begin
                edata_next = ({8'd0, ridx_reg} < kept_len_reg && {8'd0, ridx_reg} < PDEPTH_C)
                             ? kp_rdata_reg : 8'd0;
            end
            gbfp_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = ekind_reg;
                    m_cls_next   = cls_reg;
                    m_id_next    = id_reg;
                    m_len_next   = len_reg;
                    m_data_next  = edata_reg;
                    n_next       = n_reg + NW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gbfp_pkg::ST_IDLE;
            phase_reg    <= gbfp_pkg::PH_HUNT;
            ptr_reg      <= '0;
            fill_reg     <= '0;
            n_reg        <= '0;
            bank_reg     <= 1'b0;
            kept_cls_reg <= 8'd0;
            kept_id_reg  <= 8'd0;
            kept_len_reg <= 16'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            ptr_reg      <= ptr_next;
            fill_reg     <= fill_next;
            n_reg        <= n_next;
            bank_reg     <= bank_next;
            kept_cls_reg <= kept_cls_next;
            kept_id_reg  <= kept_id_next;
            kept_len_reg <= kept_len_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cls_reg      <= cls_next;
        id_reg       <= id_next;
        lo_reg       <= lo_next;
        len_reg      <= len_next;
        i_reg        <= i_next;
        sum_a_reg    <= sum_a_next;
        sum_b_reg    <= sum_b_next;
        ck_a_reg     <= ck_a_next;
        ridx_reg     <= ridx_next;
        ekind_reg    <= ekind_next;
        edata_reg    <= edata_next;
        ret_idle_reg <= ret_idle_next;
        m_kind_reg   <= m_kind_next;
        m_cls_reg    <= m_cls_next;
        m_id_reg     <= m_id_next;
        m_len_reg    <= m_len_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_cls   = m_cls_reg;
    assign m_id    = m_id_reg;
    assign m_len   = m_len_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: sv/gnss_binary_frame_parser.sv
//==============================================================================
// gnss_binary_frame_parser
// Sync hunt, header and length check, Fletcher checksum, kept payload reads
//==============================================================================
// order: a read item passes ST_RD_DATA and ST_EMIT to its registered result;
//   a received byte runs the sync hunt (ST_H0, ST_H1), the header (ST_F0 to
//   ST_F3), the checksum pass over class, id, length and payload (ST_CK_IS,
//   ST_CK_AC per byte), then ST_CS_IS, ST_CS0, ST_CS1 and ST_EMIT
// pacing: set by the single read port of the frame buffer; the engine takes
//   items only when idle and the two-entry queue holds items meanwhile
// reset: synchronous active-low aresetn clears control state and restores
//   the register defaults; buffer memories are not cleared
`default_nettype none

module gnss_binary_frame_parser #(
    parameter int FRAME_DEPTH   = gbfp_pkg::FRAME_DEPTH,
    parameter int PAYLOAD_DEPTH = gbfp_pkg::PAYLOAD_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic [7:0]  s_read_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [7:0]       m_msg_class,
    output logic [7:0]       m_msg_id,
    output logic [15:0]      m_payload_length,
    output logic [7:0]       m_data_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    gbfp_pkg::cfg_t  cfg_reg, cfg_next;
    gbfp_pkg::item_t s_item, q_item;
    gbfp_pkg::kind_t m_kind;
    logic            q_valid, q_pop;

    assign cfg_ready = 1'b1;

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                gbfp_pkg::CFG_SYNC_FIRST:  cfg_next.sync_first  = cfg_data;
                gbfp_pkg::CFG_SYNC_SECOND: cfg_next.sync_second = cfg_data;
                gbfp_pkg::CFG_MAX_LEN:     cfg_next.max_len     = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first  <= gbfp_pkg::SYNC_FIRST_RST;
            cfg_reg.sync_second <= gbfp_pkg::SYNC_SECOND_RST;
            cfg_reg.max_len     <= gbfp_pkg::MAX_LEN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_item.req_type   = s_req_type;
    assign s_item.rx_byte    = s_rx_byte;
    assign s_item.read_index = s_read_index;

    gbfp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    gbfp_back #(
        .FRAME_DEPTH   (FRAME_DEPTH),
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
        .MAX_RESULTS   (gbfp_pkg::MAX_RESULTS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_kind  (m_kind),
        .m_cls   (m_msg_class),
        .m_id    (m_msg_id),
        .m_len   (m_payload_length),
        .m_data  (m_data_byte)
    );

    assign m_result_kind = m_kind;

    // frame results never carry a data byte
    a_frame_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != gbfp_pkg::KIND_READ |-> m_data_byte == 8'd0)
        else $error("frame item with nonzero data byte");

    // a good frame respects the configured length limit
    a_valid_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == gbfp_pkg::KIND_VALID
        |-> m_payload_length <= {8'd0, cfg_reg.max_len})
        else $error("valid frame longer than limit");

    // a length error reports a length beyond the limit in force
    a_len_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == gbfp_pkg::KIND_LEN
        |-> (m_payload_length > {8'd0, cfg_reg.max_len}
             || m_payload_length > 16'(FRAME_DEPTH - gbfp_pkg::FRAME_OVERHEAD)))
        else $error("length error on an acceptable length");

endmodule

`default_nettype wire

FILE: verif/tb_gnss_binary_frame_parser.sv
//==============================================================================
// tb_gnss_binary_frame_parser
// Self-checking bench: directed frames and reads from a table, then random
// frames and noise, all checked against a behavioral frame parser model
//==============================================================================
`timescale 1ns / 100ps
`default_nettype none

module tb_gnss_binary_frame_parser;

    localparam int CLK_HALF = 6;
    localparam int CYCLE_LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [7:0]  s_rx_byte;
    logic [7:0]  s_read_index;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_msg_class;
    logic [7:0]  m_msg_id;
    logic [15:0] m_payload_length;
    logic [7:0]  m_data_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    typedef struct packed {
        gbfp_pkg::kind_t kind;
        logic [7:0]      cls;
        logic [7:0]      id;
        logic [15:0]     len;
        logic [7:0]      data;
    } report_t;

    gnss_binary_frame_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_rx_byte(s_rx_byte), .s_read_index(s_read_index),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
        .m_msg_class(m_msg_class), .m_msg_id(m_msg_id),
        .m_payload_length(m_payload_length), .m_data_byte(m_data_byte),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // parser model state
    logic [7:0]       mdl_sync1, mdl_sync2, mdl_maxlen;
    gbfp_pkg::phase_t mdl_phase;
    logic [7:0]       mdl_buf [gbfp_pkg::FRAME_DEPTH];
    int               mdl_fill, mdl_head;
    logic [7:0]       mdl_kept [gbfp_pkg::PAYLOAD_DEPTH];
    logic [7:0]       kept_cls, kept_id;
    logic [15:0]      kept_len;

    report_t     pending_reports[$];
    int          fail_count;
    int          mismatch_count;
    int          cycle_count;
    bit          hold_off;
    bit          frame_seen;

    always #CLK_HALF aclk = ~aclk;

    function automatic logic [7:0] buf_at(int k);
        return mdl_buf[(mdl_head + k) % gbfp_pkg::FRAME_DEPTH];
    endfunction

    function automatic void buf_drop(int n);
        if (n > mdl_fill) n = mdl_fill;
        mdl_head = (mdl_head + n) % gbfp_pkg::FRAME_DEPTH;
        mdl_fill -= n;
    endfunction

    function automatic void push_report(gbfp_pkg::kind_t k, logic [7:0] c,
                                        logic [7:0] i, logic [15:0] l,
                                        logic [7:0] d);
        report_t r;
        r.kind = k; r.cls = c; r.id = i; r.len = l; r.data = d;
        pending_reports.push_back(r);
    endfunction

    // advance the parser model by one item and queue its reports
    function automatic void parse_item(logic rt, logic [7:0] rx, logic [7:0] ridx);
        int n;
        int lim;
        int len;
        logic [7:0] sa, sb;
        n = 0;
        if (rt) begin
            push_report(gbfp_pkg::KIND_READ, kept_cls, kept_id, kept_len, mdl_kept[ridx]);
            return;
        end
        if (mdl_fill < gbfp_pkg::FRAME_DEPTH) begin
            mdl_buf[(mdl_head + mdl_fill) % gbfp_pkg::FRAME_DEPTH] = rx;
            mdl_fill++;
        end
        lim = (mdl_maxlen > gbfp_pkg::FRAME_DEPTH - gbfp_pkg::FRAME_OVERHEAD) ?
              gbfp_pkg::FRAME_DEPTH - gbfp_pkg::FRAME_OVERHEAD : mdl_maxlen;
        while (n < gbfp_pkg::MAX_RESULTS) begin
            if (mdl_phase == gbfp_pkg::PH_HUNT) begin
                while (mdl_fill >= 2) begin
                    if (buf_at(0) == mdl_sync1 && buf_at(1) == mdl_sync2) begin
                        buf_drop(2);
                        mdl_phase = gbfp_pkg::PH_FRAME;
                        break;
                    end
                    buf_drop(1);
                end
                if (mdl_phase == gbfp_pkg::PH_HUNT) break;
            end
            if (mdl_fill < gbfp_pkg::HEADER_BYTES) break;
            len = {buf_at(3), buf_at(2)};
            if (len > lim) begin
                push_report(gbfp_pkg::KIND_LEN, buf_at(0), buf_at(1), len[15:0], 8'h00);
                n++;
                mdl_phase = gbfp_pkg::PH_HUNT;
                continue;
            end
            if (mdl_fill < len + gbfp_pkg::FRAME_OVERHEAD) break;
            sa = 0; sb = 0;
            for (int i = 0; i < len + gbfp_pkg::HEADER_BYTES; i++) begin
                sa += buf_at(i);
                sb += sa;
            end
            mdl_phase = gbfp_pkg::PH_HUNT;
            if (sa == buf_at(len + 4) && sb == buf_at(len + 5)) begin
                foreach (mdl_kept[i]) mdl_kept[i] = 8'h00;
                for (int i = 0; i < len; i++) mdl_kept[i] = buf_at(4 + i);
                kept_cls = buf_at(0); kept_id = buf_at(1); kept_len = len[15:0];
                push_report(gbfp_pkg::KIND_VALID, kept_cls, kept_id, kept_len, 8'h00);
                buf_drop(len + gbfp_pkg::FRAME_OVERHEAD);
                frame_seen = 1'b1;
            end else begin
                push_report(gbfp_pkg::KIND_CSUM, buf_at(0), buf_at(1), len[15:0], 8'h00);
            end
            n++;
        end
    endfunction

    // send one item, with the handshake completing at a rising edge
    task automatic send_item(logic rt, logic [7:0] rx, logic [7:0] ridx);
        s_valid = 1'b1;
        s_req_type = rt;
        s_rx_byte = rx;
        s_read_index = ridx;
        do @(posedge aclk); while (!s_ready);
        parse_item(rt, rx, ridx);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // random gap in bursts
    int burst_left;
    task automatic sender_gap();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic send_bytes(logic [7:0] bytes[$]);
        foreach (bytes[i]) begin
            send_item(1'b0, bytes[i], 8'($urandom));
            sender_gap();
        end
    endtask

    // frame with sync, header, payload and Fletcher sums, optionally corrupted
    function automatic void build_frame(ref logic [7:0] q[$], input logic [7:0] c,
                                        input logic [7:0] i, input int len,
                                        input bit bad_sum);
        logic [7:0] sa, sb;
        logic [7:0] body[$];
        body = '{c, i, 8'(len), 8'(len >> 8)};
        for (int k = 0; k < len; k++) body.push_back(8'($urandom));
        sa = 0; sb = 0;
        foreach (body[k]) begin
            sa += body[k];
            sb += sa;
        end
        if (bad_sum) sa ^= 8'(1 << $urandom_range(0, 7));
        q.push_back(mdl_sync1);
        q.push_back(mdl_sync2);
        foreach (body[k]) q.push_back(body[k]);
        q.push_back(sa);
        q.push_back(sb);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            gbfp_pkg::CFG_SYNC_FIRST: mdl_sync1 = val;
            gbfp_pkg::CFG_SYNC_SECOND: mdl_sync2 = val;
            default: mdl_maxlen = val;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // let the block drain before touching registers
    task automatic wait_idle();
        while (pending_reports.size() != 0) @(negedge aclk);
        repeat (600) @(negedge aclk);
    endtask

    // receiver stall pattern, with a long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (cycle_count % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // result checking
    always @(posedge aclk) begin
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                fail_count++;
                if (mismatch_count++ < 10)
                    $display("unexpected result kind %0d", m_result_kind);
            end else begin
                want = pending_reports.pop_front();
                if (m_result_kind !== want.kind || m_msg_class !== want.cls ||
                    m_msg_id !== want.id || m_payload_length !== want.len ||
                    m_data_byte !== want.data) begin
                    fail_count++;
                    if (mismatch_count++ < 10)
                        $display("mismatch exp %0d %h %h %h %h got %0d %h %h %h %h",
                                 want.kind, want.cls, want.id, want.len, want.data,
                                 m_result_kind, m_msg_class, m_msg_id,
                                 m_payload_length, m_data_byte);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // long receiver hold-off counted here
    task automatic hold_receiver(int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(negedge aclk);
        hold_off = 1'b0;
    endtask

    typedef struct {
        logic       rt;
        logic [7:0] rx;
        logic [7:0] ridx;
        bit         typed;
        report_t    want;
    } stim_row_t;

    initial begin
        stim_row_t  rows[$];
        stim_row_t  row;
        logic [7:0] q[$];
        int         sent;
        int         len;

        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = 1'b0;
        s_rx_byte = 8'h00;
        s_read_index = 8'h00;
        cfg_valid = 1'b0;
        cfg_index = gbfp_pkg::CFG_SYNC_FIRST;
        cfg_data = 8'h00;
        fail_count = 0;
        mismatch_count = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        frame_seen = 1'b0;
        burst_left = 0;
        mdl_sync1 = gbfp_pkg::SYNC_FIRST_RST;
        mdl_sync2 = gbfp_pkg::SYNC_SECOND_RST;
        mdl_maxlen = gbfp_pkg::MAX_LEN_RST;
        mdl_phase = gbfp_pkg::PH_HUNT;
        mdl_fill = 0;
        mdl_head = 0;
        foreach (mdl_buf[i]) mdl_buf[i] = 8'h00;
        foreach (mdl_kept[i]) mdl_kept[i] = 8'h00;
        kept_cls = 0; kept_id = 0; kept_len = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table: empty-payload frame, length error, reads at the extremes
        q = {};
        build_frame(q, 8'hFF, 8'h00, 0, 1'b0);
        foreach (q[i]) rows.push_back('{1'b0, q[i], 8'h00, 1'b0, '0});
        rows.push_back('{1'b1, 8'h00, 8'h00, 1'b1,
                         '{gbfp_pkg::KIND_READ, 8'hFF, 8'h00, 16'd0, 8'h00}});
        rows.push_back('{1'b1, 8'hFF, 8'hFF, 1'b1,
                         '{gbfp_pkg::KIND_READ, 8'hFF, 8'h00, 16'd0, 8'h00}});
        // length 0xFFFF is far over the limit
        rows.push_back('{1'b0, 8'hB5, 8'h00, 1'b0, '0});
        rows.push_back('{1'b0, 8'h62, 8'h00, 1'b0, '0});
        rows.push_back('{1'b0, 8'h00, 8'h00, 1'b0, '0});
        rows.push_back('{1'b0, 8'hFF, 8'h00, 1'b0, '0});
        rows.push_back('{1'b0, 8'hFF, 8'h00, 1'b0, '0});
        rows.push_back('{1'b0, 8'hFF, 8'h00, 1'b1,
                         '{gbfp_pkg::KIND_LEN, 8'h00, 8'hFF, 16'hFFFF, 8'h00}});
        foreach (rows[i]) begin
            row = rows[i];
            if (row.typed) begin
                // typed rows must agree with the model's own prediction
                send_item(row.rt, row.rx, row.ridx);
                if (pending_reports.size() == 0 || pending_reports[$] != row.want) begin
                    fail_count++;
                    if (mismatch_count++ < 10) $display("table row %0d disagrees", i);
                end
            end else begin
                send_item(row.rt, row.rx, row.ridx);
            end
        end
        wait_idle();

        // register settings including extremes, random traffic in each
        for (int phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0: begin
                    write_reg(gbfp_pkg::CFG_MAX_LEN, 8'd0);
                end
                1: begin
                    write_reg(gbfp_pkg::CFG_SYNC_FIRST, 8'h00);
                    write_reg(gbfp_pkg::CFG_SYNC_SECOND, 8'hFF);
                    write_reg(gbfp_pkg::CFG_MAX_LEN, 8'd250);
                end
                2: begin
                    write_reg(gbfp_pkg::CFG_SYNC_FIRST, 8'hFF);
                    write_reg(gbfp_pkg::CFG_SYNC_SECOND, 8'h00);
                    write_reg(gbfp_pkg::CFG_MAX_LEN, 8'd12);
                end
                default: begin
                    write_reg(gbfp_pkg::CFG_SYNC_FIRST, gbfp_pkg::SYNC_FIRST_RST);
                    write_reg(gbfp_pkg::CFG_SYNC_SECOND, gbfp_pkg::SYNC_SECOND_RST);
                    write_reg(gbfp_pkg::CFG_MAX_LEN, gbfp_pkg::MAX_LEN_RST);
                end
            endcase
            sent = 0;
            while (sent < 65) begin
                q = {};
                case ($urandom_range(0, 9))
                    0: begin
                        // noise
                        repeat ($urandom_range(1, 5)) q.push_back(8'($urandom));
                    end
                    1: begin
                        // length over the limit
                        q = '{mdl_sync1, mdl_sync2, 8'($urandom), 8'($urandom),
                              8'(mdl_maxlen + 1 + $urandom_range(0, 4)),
                              8'($urandom_range(0, 1))};
                    end
                    2: build_frame(q, 8'($urandom), 8'($urandom),
                                   $urandom_range(0, mdl_maxlen < 8 ? mdl_maxlen : 8), 1'b1);
                    9: begin
                        // occasional long frame
                        len = $urandom_range(0, mdl_maxlen > 250 ? 250 : mdl_maxlen);
                        build_frame(q, 8'($urandom), 8'($urandom), len, 1'b0);
                    end
                    default: build_frame(q, 8'($urandom), 8'($urandom),
                                         $urandom_range(0, mdl_maxlen < 10 ? mdl_maxlen : 10),
                                         1'b0);
                endcase
                send_bytes(q);
                sent += q.size();
                if (frame_seen && $urandom_range(0, 2) == 0) begin
                    send_item(1'b1, 8'($urandom), 8'($urandom_range(0, 12)));
                    send_item(1'b1, 8'($urandom), 8'($urandom));
                    sent += 2;
                end
            end
            // long receiver stall while the sender keeps offering
            if (phase_no == 1) begin
                fork
                    hold_receiver(400);
                    begin
                        q = {};
                        repeat (6) build_frame(q, 8'($urandom), 8'($urandom), 0, 1'b1);
                        foreach (q[i]) send_item(1'b0, q[i], 8'h00);
                    end
                join
            end
            wait_idle();
        end

        if (fail_count == 0 && pending_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
